### rtl/multiplexed_led_pwm_scanner_defines.svh
// assertion macros for the led pwm scanner
`ifndef MULTIPLEXED_LED_PWM_SCANNER_DEFINES_SVH
`define MULTIPLEXED_LED_PWM_SCANNER_DEFINES_SVH

// property checked on every clock edge outside reset
`define MLPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MLPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mlps_pkg.sv
// shared types, constants and helpers for the led pwm scanner
`timescale 1ns / 1ps
`default_nettype none

package mlps_pkg;

    localparam int LED_COUNT   = 18;
    localparam int LEVEL_STEPS = 16;
    localparam int MAX_GROUPS  = 3;

    localparam int PHASE_W  = $clog2(LEVEL_STEPS);
    localparam int LEVEL_W  = 5;
    localparam int INDEX_W  = 5;
    localparam int GROUP_W  = 2;
    localparam int MAP_W    = 36;
    localparam int GAIN_W   = 8;
    localparam int LIT_W    = 5;
    localparam int DRIVE_W  = 13;
    localparam int MASK_W   = 18;
    localparam int GCOUNT_W = 3;

    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(LEVEL_STEPS - 1);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = LEVEL_W'(LEVEL_STEPS);

    // item command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // configuration port
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_GROUP_MAP   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GROUP_COUNT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_GROUP0 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_GROUP1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_GROUP2 = 3'd4;

    localparam logic [MAP_W-1:0]   RST_GROUP_MAP   = 36'd19634136210;
    localparam logic [GROUP_W-1:0] RST_GROUP_COUNT = 2'd3;
    localparam logic [GAIN_W-1:0]  RST_GAIN_GROUP0 = 8'd72;
    localparam logic [GAIN_W-1:0]  RST_GAIN_GROUP1 = 8'd72;
    localparam logic [GAIN_W-1:0]  RST_GAIN_GROUP2 = 8'd100;

    typedef struct packed {
        logic [0:0]         cmd;
        logic [INDEX_W-1:0] led_index;
        logic [LEVEL_W-1:0] level;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0]  on_mask;
        logic [MASK_W-1:0]  off_mask;
        logic [GROUP_W-1:0] active_group;
        logic [LIT_W-1:0]   lit_count;
        logic [DRIVE_W-1:0] drive_group0;
        logic [DRIVE_W-1:0] drive_group1;
        logic [DRIVE_W-1:0] drive_group2;
    } t_out_item;

    typedef struct packed {
        logic [MAP_W-1:0]                  group_map;
        logic [GROUP_W-1:0]                group_count;
        logic [MAX_GROUPS-1:0][GAIN_W-1:0] gain;
    } t_cfg;

    // compare value of one current source
    function automatic logic [DRIVE_W-1:0] drive_value(
        input logic [LIT_W-1:0]   lit,
        input logic [GAIN_W-1:0]  gain,
        input logic [GROUP_W-1:0] active,
        input logic [GROUP_W-1:0] grp
    );
        logic [DRIVE_W-1:0] prod;
        prod = DRIVE_W'(lit) * DRIVE_W'(gain);
        return (active == grp) ? prod : '0;
    endfunction

endpackage

`default_nettype wire

### rtl/mlps_cfg_regs.sv
// apb register file for the led pwm scanner
`timescale 1ns / 1ps
`default_nettype none

module mlps_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mlps_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mlps_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mlps_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output mlps_pkg::t_cfg                      o_cfg
);

    mlps_pkg::t_cfg                  r_cfg;
    mlps_pkg::t_cfg                  n_cfg;
    logic [mlps_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                            wr_en;

    // registers sit on 8-byte boundaries
    assign reg_idx = paddr[mlps_pkg::APB_ADDR_W-1:mlps_pkg::APB_ADDR_W-mlps_pkg::REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                mlps_pkg::REG_GROUP_MAP:   n_cfg.group_map   = pwdata[mlps_pkg::MAP_W-1:0];
                mlps_pkg::REG_GROUP_COUNT: n_cfg.group_count = pwdata[mlps_pkg::GROUP_W-1:0];
                mlps_pkg::REG_GAIN_GROUP0: n_cfg.gain[0]     = pwdata[mlps_pkg::GAIN_W-1:0];
                mlps_pkg::REG_GAIN_GROUP1: n_cfg.gain[1]     = pwdata[mlps_pkg::GAIN_W-1:0];
                mlps_pkg::REG_GAIN_GROUP2: n_cfg.gain[2]     = pwdata[mlps_pkg::GAIN_W-1:0];
                default:                   n_cfg             = r_cfg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            mlps_pkg::REG_GROUP_MAP:   prdata = mlps_pkg::APB_DATA_W'(r_cfg.group_map);
            mlps_pkg::REG_GROUP_COUNT: prdata = mlps_pkg::APB_DATA_W'(r_cfg.group_count);
            mlps_pkg::REG_GAIN_GROUP0: prdata = mlps_pkg::APB_DATA_W'(r_cfg.gain[0]);
            mlps_pkg::REG_GAIN_GROUP1: prdata = mlps_pkg::APB_DATA_W'(r_cfg.gain[1]);
            mlps_pkg::REG_GAIN_GROUP2: prdata = mlps_pkg::APB_DATA_W'(r_cfg.gain[2]);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.group_map   <= mlps_pkg::RST_GROUP_MAP;
            r_cfg.group_count <= mlps_pkg::RST_GROUP_COUNT;
            r_cfg.gain[0]     <= mlps_pkg::RST_GAIN_GROUP0;
            r_cfg.gain[1]     <= mlps_pkg::RST_GAIN_GROUP1;
            r_cfg.gain[2]     <= mlps_pkg::RST_GAIN_GROUP2;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

### rtl/multiplexed_led_pwm_scanner.sv
// top level of the multiplexed led pwm scanner
`timescale 1ns / 1ps
`default_nettype none
`include "multiplexed_led_pwm_scanner_defines.svh"

// Multiplexed LED PWM scanner. A write item (cmd = 1) stores a level 0..16 for one
// LED and gives no result; levels above 16 are clamped and writes to LEDs past 17
// are dropped. A tick item (cmd = 0) advances the 0..15 phase; on wrap the active
// group steps modulo group_count (0 acts as 1). Each tick gives one result item:
// on/off masks of the LEDs mapped to the active group, the lit count and the per-group
// current source compares (lit count times gain for the active group, zero elsewhere).
// The block takes one item per cycle without gaps while the result output is not stalled. A tick
// result passes the state update at acceptance, the mask and count evaluation register,
// then the output register where the gain multiply lands. Configuration sits on the APB
// port at 8-byte steps; the user must write it only while idle, unchecked by the block.

module multiplexed_led_pwm_scanner (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // item input
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire mlps_pkg::t_in_item              i_item,
    // result output
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output mlps_pkg::t_out_item                  o_item,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mlps_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mlps_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mlps_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    // evaluation register contents
    typedef struct packed {
        logic [mlps_pkg::MASK_W-1:0]  on_mask;
        logic [mlps_pkg::MASK_W-1:0]  off_mask;
        logic [mlps_pkg::GROUP_W-1:0] group;
        logic [mlps_pkg::LIT_W-1:0]   lit;
    } t_eval;

    mlps_pkg::t_cfg cfg;

    // scan state
    logic [mlps_pkg::LEVEL_W-1:0] r_levels [mlps_pkg::LED_COUNT];
    logic [mlps_pkg::LEVEL_W-1:0] n_levels [mlps_pkg::LED_COUNT];
    logic [mlps_pkg::PHASE_W-1:0] r_phase;
    logic [mlps_pkg::PHASE_W-1:0] n_phase;
    logic [mlps_pkg::GROUP_W-1:0] r_group;
    logic [mlps_pkg::GROUP_W-1:0] n_group;

    // pipeline
    logic                r_s1_valid;
    logic                n_s1_valid;
    logic                r_s2_valid;
    logic                n_s2_valid;
    t_eval               r_s2;
    t_eval               n_s2;
    logic                r_out_valid;
    logic                n_out_valid;
    mlps_pkg::t_out_item r_out;
    mlps_pkg::t_out_item n_out;

    logic                             out_free;
    logic                             s2_free;
    logic                             accept;
    logic                             is_tick;
    logic [mlps_pkg::GCOUNT_W-1:0]    eff_groups;
    logic [mlps_pkg::GCOUNT_W-1:0]    group_inc;
    logic [mlps_pkg::LEVEL_W-1:0]     wr_level;
    t_eval                            eval;

    // helpers for the checks
    logic [mlps_pkg::LIT_W-1:0]       on_count;
    logic                             tick_wrap;

    mlps_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake: every stage moves when the one after it frees up
    assign out_free = !r_out_valid || i_ready;
    assign s2_free  = !r_s2_valid || out_free;
    assign o_ready  = !r_s1_valid || s2_free;
    assign accept   = i_valid && o_ready;
    assign is_tick  = (i_item.cmd == mlps_pkg::CMD_TICK);
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;

    // group count zero scans only group zero, counts above the limit are capped
    always_comb begin
        eff_groups = mlps_pkg::GCOUNT_W'(cfg.group_count);
        if (eff_groups == '0) begin
            eff_groups = mlps_pkg::GCOUNT_W'(1);
        end
        if (eff_groups > mlps_pkg::GCOUNT_W'(mlps_pkg::MAX_GROUPS)) begin
            eff_groups = mlps_pkg::GCOUNT_W'(mlps_pkg::MAX_GROUPS);
        end
    end

    assign group_inc = mlps_pkg::GCOUNT_W'(r_group) + mlps_pkg::GCOUNT_W'(1);
    assign wr_level  = (i_item.level > mlps_pkg::LEVEL_MAX) ? mlps_pkg::LEVEL_MAX
                                                            : i_item.level;

    // state update at acceptance
    always_comb begin
        n_levels = r_levels;
        n_phase  = r_phase;
        n_group  = r_group;
        if (accept) begin
            if (is_tick) begin
                if (r_phase == mlps_pkg::PHASE_LAST) begin
                    n_phase = '0;
                    // a lowered count sends an index at or above it back to zero
                    n_group = (group_inc >= eff_groups) ? '0
                                                        : group_inc[mlps_pkg::GROUP_W-1:0];
                end else begin
                    n_phase = r_phase + mlps_pkg::PHASE_W'(1);
                end
            end else begin
                for (int i = 0; i < mlps_pkg::LED_COUNT; i++) begin
                    if (i_item.led_index == mlps_pkg::INDEX_W'(i)) begin
                        n_levels[i] = wr_level;
                    end
                end
            end
        end
    end

    // per-led compare against the phase; map code three never matches an active group
    always_comb begin
        eval       = '0;
        eval.group = r_group;
        for (int i = 0; i < mlps_pkg::LED_COUNT; i++) begin
            if (cfg.group_map[2*i +: mlps_pkg::GROUP_W] == r_group) begin
                if (r_levels[i] > mlps_pkg::LEVEL_W'(r_phase)) begin
                    eval.on_mask[i] = 1'b1;
                    eval.lit        = eval.lit + mlps_pkg::LIT_W'(1);
                end else begin
                    eval.off_mask[i] = 1'b1;
                end
            end
        end
    end

    // stage two holds the evaluation, the output stage adds the gain multiplies
    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_s2_valid  = r_s2_valid;
        n_s2        = r_s2;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (out_free) begin
            n_out_valid = r_s2_valid;
            if (r_s2_valid) begin
                n_out.on_mask      = r_s2.on_mask;
                n_out.off_mask     = r_s2.off_mask;
                n_out.active_group = r_s2.group;
                n_out.lit_count    = r_s2.lit;
                n_out.drive_group0 = mlps_pkg::drive_value(r_s2.lit, cfg.gain[0],
                                                           r_s2.group, 2'd0);
                n_out.drive_group1 = mlps_pkg::drive_value(r_s2.lit, cfg.gain[1],
                                                           r_s2.group, 2'd1);
                n_out.drive_group2 = mlps_pkg::drive_value(r_s2.lit, cfg.gain[2],
                                                           r_s2.group, 2'd2);
            end
        end

        if (s2_free) begin
            n_s2_valid = r_s1_valid;
            if (r_s1_valid) begin
                n_s2 = eval;
            end
            n_s1_valid = 1'b0;
        end

        // a tick leaves a marker; the state it left is read when stage two takes the marker
        if (accept && is_tick) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_group     <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < mlps_pkg::LED_COUNT; i++) begin
                r_levels[i] <= '0;
            end
        end else begin
            r_phase     <= n_phase;
            r_group     <= n_group;
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_out_valid <= n_out_valid;
            r_levels    <= n_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2  <= n_s2;
        r_out <= n_out;
    end

    // checks
    assign on_count  = mlps_pkg::LIT_W'($countones(o_item.on_mask));
    assign tick_wrap = accept && is_tick && (r_phase == mlps_pkg::PHASE_LAST);

    `MLPS_ASSERT(a_stall_full, !o_ready |-> (!s2_free && !out_free), "stall with a free stage")
    `MLPS_ASSERT(a_disjoint, o_valid |-> !(|(o_item.on_mask & o_item.off_mask)), "led on and off")
    `MLPS_ASSERT(a_lit_matches, o_valid |-> (on_count == o_item.lit_count), "bad lit count")
    `MLPS_ASSERT_NEXT(a_write_hold, accept && !is_tick, $stable({r_phase, r_group}), "scan moved")
    `MLPS_ASSERT_NEXT(a_phase_wrap, tick_wrap, r_phase == '0, "phase did not wrap")

endmodule

`default_nettype wire

### verif/tb.sv
// testbench for the multiplexed led pwm scanner
`timescale 1ns / 1ps

module tb;
    import mlps_pkg::*;

    // receiver hold-off used to fill the block and stall its input
    localparam int HOLD_CYCLES   = 300;
    // quiet cycles after the last scan result before touching registers
    localparam int SETTLE_CYCLES = 8;
    // bound on waiting for outstanding scan results
    localparam int DRAIN_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 30;

    // clock, reset and block inputs, all known from time zero
    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_item              in_item  = '0;
    logic                  out_ready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;

    // block outputs
    logic                  in_ready;
    logic                  out_valid;
    t_out_item             out_item;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // mirror of the scanner state and its registers
    logic [LEVEL_W-1:0]    lvl_mirror [LED_COUNT];
    logic [PHASE_W-1:0]    phase_mirror;
    logic [GROUP_W-1:0]    group_mirror;
    logic [MAP_W-1:0]      map_mirror;
    logic [GROUP_W-1:0]    count_mirror;
    logic [GAIN_W-1:0]     gain_mirror [MAX_GROUPS];

    // scan results still owed by the block, oldest first
    t_out_item             expected_scans [$];
    int                    mismatches = 0;
    // idling on both sides, switched off for some stretches
    bit                    gaps_on = 1'b1;
    // request for the receiver to hold off for a long stretch
    bit                    hold_req = 1'b0;

    always #1 i_clk = ~i_clk;

    multiplexed_led_pwm_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_item  (out_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // count a failure, print only the first few
    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch: %s", what);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
            note_mismatch($sformatf("%s expected %0h actual %0h", name, want, got));
    endfunction

    function automatic t_in_item make_item(input logic cmd, input int idx, input int lvl);
        t_in_item it;
        it.cmd       = cmd;
        it.led_index = INDEX_W'(idx);
        it.level     = LEVEL_W'(lvl);
        return it;
    endfunction

    // tick with random content in the fields the block ignores
    function automatic t_in_item tick_item();
        return make_item(CMD_TICK, $urandom_range(0, 31), $urandom_range(0, 31));
    endfunction

    // mostly in-range writes and ticks, some writes past the last led or above full level
    function automatic t_in_item random_item();
        t_in_item it;
        it.cmd = ($urandom_range(0, 9) < 4) ? CMD_WRITE : CMD_TICK;
        it.led_index = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom_range(LED_COUNT, 31))
                                                   : INDEX_W'($urandom_range(0, LED_COUNT - 1));
        it.level = ($urandom_range(0, 9) == 0) ? LEVEL_W'($urandom_range(LEVEL_STEPS + 1, 31))
                                               : LEVEL_W'($urandom_range(0, LEVEL_STEPS));
        return it;
    endfunction

    // advance the mirror by one accepted item and queue the scan it produces
    function automatic void advance_scan(input t_in_item it);
        t_out_item          scan;
        int                 groups;
        logic [GROUP_W-1:0] code;
        logic [DRIVE_W-1:0] drive [MAX_GROUPS];
        if (it.cmd == CMD_WRITE) begin
            // writes past the last led are dropped, levels saturate at full on
            if (it.led_index < LED_COUNT)
                lvl_mirror[it.led_index] = (it.level > LEVEL_MAX) ? LEVEL_MAX : it.level;
            return;
        end
        // a count of zero scans group zero only
        groups = (count_mirror == '0) ? 1 : int'(count_mirror);
        if (phase_mirror == PHASE_LAST) begin
            phase_mirror = '0;
            // a lowered count takes effect here, at the phase wrap
            group_mirror = (int'(group_mirror) + 1 >= groups) ? '0 : group_mirror + 1'b1;
        end else begin
            phase_mirror = phase_mirror + 1'b1;
        end
        scan = '0;
        scan.active_group = group_mirror;
        for (int i = 0; i < LED_COUNT; i++) begin
            code = map_mirror[2*i +: 2];
            // leds mapped to code three never match an active group
            if (code == group_mirror) begin
                if (lvl_mirror[i] > phase_mirror) begin
                    scan.on_mask[i] = 1'b1;
                    scan.lit_count  = scan.lit_count + 1'b1;
                end else begin
                    scan.off_mask[i] = 1'b1;
                end
            end
        end
        for (int g = 0; g < MAX_GROUPS; g++)
            drive[g] = (g == group_mirror) ? DRIVE_W'(scan.lit_count) * DRIVE_W'(gain_mirror[g])
                                           : '0;
        scan.drive_group0 = drive[0];
        scan.drive_group1 = drive[1];
        scan.drive_group2 = drive[2];
        expected_scans.push_back(scan);
    endfunction

    // offer one item after a random gap and wait for the handshake
    task automatic send_item(input t_in_item it);
        int gap;
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        advance_scan(it);
    endtask

    // stop offering, wait for every owed scan, then let the pipeline settle
    task automatic drain();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (expected_scans.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_scans.size() != 0) begin
            note_mismatch($sformatf("%0d scan results never arrived", expected_scans.size()));
            expected_scans.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GROUP_MAP:   map_mirror     = value[MAP_W-1:0];
            REG_GROUP_COUNT: count_mirror   = value[GROUP_W-1:0];
            REG_GAIN_GROUP0: gain_mirror[0] = value[GAIN_W-1:0];
            REG_GAIN_GROUP1: gain_mirror[1] = value[GAIN_W-1:0];
            REG_GAIN_GROUP2: gain_mirror[2] = value[GAIN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic read_reg(input logic [REG_IDX_W-1:0] idx,
                            output logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'({idx, 3'b000});
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [MAP_W-1:0] map, input logic [GROUP_W-1:0] count,
                              input int g0, input int g1, input int g2);
        write_reg(REG_GROUP_MAP, APB_DATA_W'(map));
        write_reg(REG_GROUP_COUNT, APB_DATA_W'(count));
        write_reg(REG_GAIN_GROUP0, APB_DATA_W'(g0));
        write_reg(REG_GAIN_GROUP1, APB_DATA_W'(g1));
        write_reg(REG_GAIN_GROUP2, APB_DATA_W'(g2));
    endtask

    // read every register and compare its low bits with the mirror
    task automatic check_readback();
        logic [REG_IDX_W-1:0]  idx;
        logic [APB_DATA_W-1:0] got;
        logic [APB_DATA_W-1:0] want;
        int                    bits;
        for (int r = 0; r <= int'(REG_GAIN_GROUP2); r++) begin
            idx = REG_IDX_W'(r);
            want = '0;
            bits = GAIN_W;
            case (idx)
                REG_GROUP_MAP:   begin want = APB_DATA_W'(map_mirror); bits = MAP_W; end
                REG_GROUP_COUNT: begin want = APB_DATA_W'(count_mirror); bits = GROUP_W; end
                REG_GAIN_GROUP0: want = APB_DATA_W'(gain_mirror[0]);
                REG_GAIN_GROUP1: want = APB_DATA_W'(gain_mirror[1]);
                REG_GAIN_GROUP2: want = APB_DATA_W'(gain_mirror[2]);
                default: ;
            endcase
            read_reg(idx, got);
            check_field($sformatf("register %0d readback", r), want,
                        got & ((64'd1 << bits) - 64'd1));
        end
    endtask

    // reset values first, then random values in every register
    task automatic test_register_access();
        check_readback();
        set_config(MAP_W'({$urandom, $urandom}), GROUP_W'($urandom), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
        check_readback();
    endtask

    // all leds in group zero at full gain: clamping, dropped writes, full drive
    task automatic test_level_edges();
        set_config('0, 2'd1, 255, 255, 255);
        for (int i = 0; i < LED_COUNT - 1; i++)
            send_item(make_item(CMD_WRITE, i, LEVEL_STEPS));
        // level above full on saturates
        send_item(make_item(CMD_WRITE, LED_COUNT - 1, 31));
        // writes past the last led change nothing
        send_item(make_item(CMD_WRITE, LED_COUNT, 0));
        send_item(make_item(CMD_WRITE, 31, 0));
        // every led lit: largest lit count and drive value
        send_item(tick_item());
        send_item(make_item(CMD_WRITE, 5, 0));
        send_item(make_item(CMD_WRITE, 6, 1));
        send_item(tick_item());
        send_item(tick_item());
        drain();
    endtask

    // count of zero, then lowering the count while a high group is active
    task automatic test_group_scan();
        int lowered [2];
        lowered[0] = 1;
        lowered[1] = 2;
        // led codes cycle through 0, 1, 2, 3 so code three leds are present
        set_config(36'hE4E4E4E4E, 2'd0, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255));
        for (int i = 0; i < LED_COUNT; i++)
            send_item(make_item(CMD_WRITE, i, $urandom_range(0, LEVEL_STEPS)));
        // a count of zero keeps the scan on group zero across wraps
        repeat (40) send_item(tick_item());
        drain();
        foreach (lowered[k]) begin
            write_reg(REG_GROUP_COUNT, APB_DATA_W'(3));
            while (group_mirror != 2'd2) send_item(tick_item());
            repeat ($urandom_range(0, 10)) send_item(tick_item());
            drain();
            // group two stays active until the next wrap, then the scan restarts at zero
            write_reg(REG_GROUP_COUNT, APB_DATA_W'(lowered[k]));
            repeat (40) send_item(tick_item());
            drain();
        end
    endtask

    // receiver holds off while items keep coming, so the input must stall
    task automatic test_backpressure();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_item(($urandom_range(0, 3) == 0) ? random_item() : tick_item());
        drain();
        gaps_on = 1'b1;
    endtask

    // random items under a series of settings, extremes among them
    task automatic test_random_scans();
        logic [MAP_W-1:0] map;
        int               g [MAX_GROUPS];
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            map = MAP_W'({$urandom, $urandom});
            if (p == 1) map = '1;
            if (p == 4) map = '0;
            foreach (g[k]) g[k] = $urandom_range(0, 255);
            if (p == 1) begin g[0] = 0; g[1] = 255; g[2] = 0; end
            if (p == 3) begin g[0] = 255; g[1] = 0; g[2] = 255; end
            set_config(map, GROUP_W'(p % 4), g[0], g[1], g[2]);
            gaps_on = (p != 2);
            repeat (PHASE_ITEMS) send_item(random_item());
            drain();
        end
        gaps_on = 1'b1;
    endtask

    // result sink: random stall before each result, long hold on request
    initial begin : result_sink
        int wait_cycles;
        forever begin
            if (hold_req) begin
                hold_req    = 1'b0;
                wait_cycles = HOLD_CYCLES;
            end else begin
                wait_cycles = gaps_on ? $urandom_range(0, 19) : 0;
            end
            if (wait_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
        end
    end

    // compare every accepted result with the oldest owed scan
    always @(posedge i_clk) begin : scan_check
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_scans.size() == 0) begin
                note_mismatch($sformatf("unexpected result %p", out_item));
            end else begin
                want = expected_scans.pop_front();
                check_field("on_mask", 64'(want.on_mask), 64'(out_item.on_mask));
                check_field("off_mask", 64'(want.off_mask), 64'(out_item.off_mask));
                check_field("active_group", 64'(want.active_group),
                            64'(out_item.active_group));
                check_field("lit_count", 64'(want.lit_count), 64'(out_item.lit_count));
                check_field("drive_group0", 64'(want.drive_group0),
                            64'(out_item.drive_group0));
                check_field("drive_group1", 64'(want.drive_group1),
                            64'(out_item.drive_group1));
                check_field("drive_group2", 64'(want.drive_group2),
                            64'(out_item.drive_group2));
            end
        end
    end

    initial begin : run_tests
        // reset state of the mirror
        foreach (lvl_mirror[i]) lvl_mirror[i] = '0;
        phase_mirror   = '0;
        group_mirror   = '0;
        map_mirror     = RST_GROUP_MAP;
        count_mirror   = RST_GROUP_COUNT;
        gain_mirror[0] = RST_GAIN_GROUP0;
        gain_mirror[1] = RST_GAIN_GROUP1;
        gain_mirror[2] = RST_GAIN_GROUP2;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_level_edges();
        test_group_scan();
        test_backpressure();
        test_random_scans();
        drain();

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #1000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
